[src/bpcm_pkg.sv]
// bpcm_pkg: shared types, constants and constant functions of the power curve mapper
// depends on nothing; imported by the mapper top level

package bpcm_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CURVE = 2'd0;
  localparam logic [1:0] REG_HMIN  = 2'd1;
  localparam logic [1:0] REG_HMAX  = 2'd2;
  localparam logic [1:0] REG_CTR   = 2'd3;

  // fixed-point formats that do not follow the fraction width
  localparam logic [15:0] EXP_ONE  = 16'd16384;   // 1.0 in Q2.14
  localparam int          LOG_FRAC = 20;          // log2 fraction bits
  localparam int          X_W      = 31;          // mantissa in Q1.30
  localparam int          M_W      = 25;          // -log2 magnitude, Q.20
  localparam int          Q_W      = 26;          // scaled magnitude, Q.20
  localparam int          QDIV_W   = 27;          // quotient bits of the inverse divider
  localparam int          N2_W     = 39;          // dividend of the inverse divider
  localparam logic [33:0] RECIP10  = 34'd104858;  // ceil(2^20 / 10)

  // side data that travels with an item
  typedef struct packed {
    logic        inv;
    logic        upper;
    logic        empty;
    logic [15:0] span;
  } sb_t;

  // exponent in Q2.14 from the curve amount
  function automatic logic [15:0] calc_exp(logic signed [8:0] c);
    logic signed [8:0] cs;
    logic [7:0]        mag;
    logic [16:0]       x;
    logic [33:0]       prod;
    logic [15:0]       e;
    if (c < -9'sd128) begin
      cs = -9'sd128;
    end else if (c > 9'sd128) begin
      cs = 9'sd128;
    end else begin
      cs = c;
    end
    mag  = 8'(-cs);
    x    = 17'(mag) * 17'd768 + 17'd5;
    prod = 34'(x) * RECIP10;
    if (cs < 9'sd0) begin
      e = EXP_ONE - 16'(prod >> 20);
    end else begin
      e = EXP_ONE + 16'(cs[7:0]) * 16'd192;
    end
    return e;
  endfunction

  // k-th repeated square root of one half, Q0.32 (evaluated at elaboration)
  function automatic logic [31:0] root_const(int k);
    logic [63:0] t;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    t = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      rem = t << 32;
      res = 64'd0;
      for (int i = 31; i >= 0; i--) begin
        bt = 64'd1 << (2 * i);
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
      end
      t = res;
    end
    return t[31:0];
  endfunction

endpackage

[src/bipolar_power_curve_mapper.sv]
// bipolar_power_curve_mapper: pipelined power-law response curve around a center point
// depends on bpcm_pkg; checked by bpcm_checker (bound from its own file)

// One controller value enters per cycle while in_ready is high and each gives one
// mapped value, in order. The pipeline has FRAC_BITS + 81 register stages (97 at
// the default of 16): 2 front stages, FRAC_BITS + 1 normalize-divide stages, 1 log
// prepare stage, 5 leading zero stages, 20 log2 squaring stages, 1 log magnitude
// stage, 1 exponent multiply stage, 27 inverse-exponent divide stages, 20 exp2
// multiply stages, then one stage each for the integer shift, the scale and the
// final offset. Each stage holds its own valid bit and moves on whenever a later
// stage has room, so bubbles close up and input is taken while a finished result
// waits at the output, as long as some stage is empty.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data; the user must
// write it only while no item is in flight, which the block does not enforce.
module bipolar_power_curve_mapper #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic signed [15:0]        in_value_in,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        out_value_out,
  // configuration write port
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);
  import bpcm_pkg::*;

  localparam int AW = FRAC_BITS + 1;        // normalized value, 0..1 inclusive
  localparam int NW = FRAC_BITS + 17;       // dividend of the normalize divider
  localparam logic [AW-1:0] ONE_A = AW'(1) << FRAC_BITS;

  // stage map
  localparam int S_F0 = 0;
  localparam int S_F1 = 1;
  localparam int S_DA = 2;
  localparam int S_P  = S_DA + AW;
  localparam int S_NM = S_P + 1;
  localparam int S_SQ = S_NM + 5;
  localparam int S_M  = S_SQ + LOG_FRAC;
  localparam int S_MU = S_M + 1;
  localparam int S_DQ = S_MU + 1;
  localparam int S_EX = S_DQ + QDIV_W;
  localparam int S_SH = S_EX + LOG_FRAC;
  localparam int S_R  = S_SH + 1;
  localparam int S_O  = S_R + 1;
  localparam int NS   = S_O + 1;

  // stage records
  typedef struct packed {
    sb_t            sb;
    logic [15:0]    rem;
    logic [AW-1:0]  low;
    logic [AW-1:0]  quo;
  } da_t;

  typedef struct packed {
    sb_t            sb;
    logic [AW-1:0]  a;
    logic           byp;
    logic [X_W-1:0] x;
    logic [4:0]     s;
  } nm_t;

  typedef struct packed {
    sb_t            sb;
    logic [AW-1:0]  a;
    logic           byp;
    logic [X_W-1:0] x;
    logic [4:0]     s;
    logic [LOG_FRAC-1:0] frac;
  } sq_t;

  typedef struct packed {
    sb_t            sb;
    logic [AW-1:0]  a;
    logic           byp;
    logic [M_W-1:0] m;
  } m_t;

  typedef struct packed {
    sb_t             sb;
    logic [AW-1:0]   a;
    logic            byp;
    logic [Q_W-1:0]  qf;
    logic [15:0]     rem;
    logic [QDIV_W-1:0] low;
    logic [QDIV_W-1:0] quo;
  } dq_t;

  typedef struct packed {
    sb_t            sb;
    logic [AW-1:0]  a;
    logic           byp;
    logic [Q_W-1:0] q;
    logic [31:0]    y;
    logic           yone;
  } ex_t;

  typedef struct packed {
    sb_t            sb;
    logic [AW-1:0]  b;
  } sh_t;

  typedef struct packed {
    sb_t            sb;
    logic [16:0]    r;
  } rr_t;

  // configuration registers
  logic signed [8:0]  curve_r;
  logic signed [15:0] hmin_r;
  logic signed [15:0] hmax_r;
  logic signed [15:0] ctr_r;
  logic [15:0]        e_r;

  // pipeline control
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] go;

  // pipeline payload
  logic               f0_inv_r;
  logic               f0_upper_r;
  logic signed [15:0] f0_v_r;
  sb_t                f1_sb_r;
  logic [15:0]        f1_n_r;
  da_t                da_r [AW];
  nm_t                p_r;
  nm_t                nm_r [5];
  sq_t                sq_r [LOG_FRAC];
  m_t                 m_r;
  dq_t                mu_r;
  dq_t                dq_r [QDIV_W];
  ex_t                ex_r [LOG_FRAC];
  sh_t                sh_r;
  rr_t                rr_r;
  logic signed [15:0] out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r <= '0;
      hmin_r  <= '0;
      hmax_r  <= 16'sd127;
      ctr_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CURVE: curve_r <= cfg_data[8:0];
        REG_HMIN:  hmin_r  <= cfg_data;
        REG_HMAX:  hmax_r  <= cfg_data;
        REG_CTR:   ctr_r   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // exponent from the curve amount, registered in the cycle after the curve register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r <= EXP_ONE;
    end else begin
      e_r <= calc_exp(curve_r);
    end
  end

  // a stage moves on when it is empty or some later stage has room
  for (genvar i = 0; i < NS; i++) begin : g_go
    assign go[i] = out_ready | ~(&vld_r[NS-1:i]);
  end

  assign vld_nxt = (go & {vld_r[NS-2:0], in_valid}) | (~go & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready      = go[0];
  assign out_valid     = vld_r[S_O];
  assign out_value_out = out_r;

  // front stage 0: saturate the input to the hard range, pick the half
  logic signed [15:0] f0_v_nxt;
  always_comb begin
    f0_v_nxt = in_value_in;
    if (f0_v_nxt < hmin_r) begin
      f0_v_nxt = hmin_r;
    end
    if (f0_v_nxt > hmax_r) begin
      f0_v_nxt = hmax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go[S_F0]) begin
      f0_inv_r   <= in_op;
      f0_v_r     <= f0_v_nxt;
      f0_upper_r <= f0_v_nxt >= ctr_r;
    end
  end

  // front stage 1: distance from the center and length of the half
  logic signed [17:0] f1_n18;
  logic signed [17:0] f1_d18;
  sb_t                f1_sb_nxt;
  logic [15:0]        f1_n_nxt;
  always_comb begin
    if (f0_upper_r) begin
      f1_n18 = 18'(f0_v_r) - 18'(ctr_r);
      f1_d18 = 18'(hmax_r) - 18'(ctr_r);
    end else begin
      f1_n18 = 18'(ctr_r) - 18'(f0_v_r);
      f1_d18 = 18'(ctr_r) - 18'(hmin_r);
    end
    f1_sb_nxt.inv   = f0_inv_r;
    f1_sb_nxt.upper = f0_upper_r;
    f1_sb_nxt.empty = f1_d18 <= 18'sd0;
    f1_sb_nxt.span  = f1_sb_nxt.empty ? 16'd0 : f1_d18[15:0];
    // inverted limits: clip the distance so the normalized value tops out at 1
    if (f1_sb_nxt.empty) begin
      f1_n_nxt = 16'd0;
    end else if (f1_n18 > f1_d18) begin
      f1_n_nxt = f1_d18[15:0];
    end else begin
      f1_n_nxt = f1_n18[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[S_F1]) begin
      f1_sb_r <= f1_sb_nxt;
      f1_n_r  <= f1_n_nxt;
    end
  end

  // normalize divider: a = (n * 2^F + d/2) / d, one quotient bit per stage
  logic [NW-1:0] da_num;
  assign da_num = {1'b0, f1_n_r, {FRAC_BITS{1'b0}}} + NW'(f1_sb_r.span >> 1);

  for (genvar i = 0; i < AW; i++) begin : g_da
    da_t         st_in;
    da_t         st_nxt;
    logic [16:0] t;
    logic [16:0] tsub;
    logic        ge;
    if (i == 0) begin : g_first
      always_comb begin
        st_in.sb  = f1_sb_r;
        st_in.rem = da_num[NW-1:AW];
        st_in.low = da_num[AW-1:0];
        st_in.quo = '0;
      end
    end else begin : g_next
      assign st_in = da_r[i-1];
    end
    always_comb begin
      t          = {st_in.rem, st_in.low[AW-1]};
      ge         = t >= {1'b0, st_in.sb.span};
      tsub       = t - {1'b0, st_in.sb.span};
      st_nxt.sb  = st_in.sb;
      st_nxt.rem = ge ? tsub[15:0] : t[15:0];
      st_nxt.low = st_in.low << 1;
      st_nxt.quo = {st_in.quo[AW-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (go[S_DA+i]) begin
        da_r[i] <= st_nxt;
      end
    end
  end

  // prepare the log: pass-through cases and the mantissa in Q1.30
  nm_t         p_nxt;
  logic [AW-1:0] p_a;
  assign p_a = da_r[AW-1].quo;
  always_comb begin
    p_nxt.sb  = da_r[AW-1].sb;
    p_nxt.a   = p_a;
    p_nxt.byp = (p_a == '0) || (p_a == ONE_A) || (e_r == EXP_ONE);
    p_nxt.x   = X_W'({p_a[FRAC_BITS-1:0], {(30 - FRAC_BITS){1'b0}}});
    p_nxt.s   = '0;
  end

  always_ff @(posedge clk) begin
    if (go[S_P]) begin
      p_r <= p_nxt;
    end
  end

  // leading zero shift: steps of 16, 8, 4, 2, 1
  for (genvar j = 0; j < 5; j++) begin : g_nm
    localparam int SH = 1 << (4 - j);
    nm_t st_in;
    nm_t st_nxt;
    if (j == 0) begin : g_first
      assign st_in = p_r;
    end else begin : g_next
      assign st_in = nm_r[j-1];
    end
    always_comb begin
      st_nxt = st_in;
      if (st_in.x[X_W-1 -: SH] == '0) begin
        st_nxt.x = st_in.x << SH;
        st_nxt.s = st_in.s | 5'(SH);
      end
    end
    always_ff @(posedge clk) begin
      if (go[S_NM+j]) begin
        nm_r[j] <= st_nxt;
      end
    end
  end

  // log2 fraction by repeated squaring, one bit per stage
  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    sq_t         st_in;
    sq_t         st_nxt;
    logic [61:0] prod;
    logic [31:0] xs;
    if (k == 0) begin : g_first
      always_comb begin
        st_in.sb   = nm_r[4].sb;
        st_in.a    = nm_r[4].a;
        st_in.byp  = nm_r[4].byp;
        st_in.x    = nm_r[4].x;
        st_in.s    = nm_r[4].s;
        st_in.frac = '0;
      end
    end else begin : g_next
      assign st_in = sq_r[k-1];
    end
    always_comb begin
      prod   = 62'(st_in.x) * 62'(st_in.x);
      xs     = prod[61:30];
      st_nxt = st_in;
      if (xs[31]) begin
        st_nxt.x = xs[31:1];
      end else begin
        st_nxt.x = xs[30:0];
      end
      st_nxt.frac = {st_in.frac[LOG_FRAC-2:0], xs[31]};
    end
    always_ff @(posedge clk) begin
      if (go[S_SQ+k]) begin
        sq_r[k] <= st_nxt;
      end
    end
  end

  // magnitude of log2: shift count minus fraction
  m_t m_nxt;
  always_comb begin
    m_nxt.sb  = sq_r[LOG_FRAC-1].sb;
    m_nxt.a   = sq_r[LOG_FRAC-1].a;
    m_nxt.byp = sq_r[LOG_FRAC-1].byp;
    m_nxt.m   = {sq_r[LOG_FRAC-1].s, {LOG_FRAC{1'b0}}}
                - M_W'(sq_r[LOG_FRAC-1].frac);
  end

  always_ff @(posedge clk) begin
    if (go[S_M]) begin
      m_r <= m_nxt;
    end
  end

  // forward scaling by the exponent, dividend for the inverse
  dq_t         mu_nxt;
  logic [40:0] mu_prod;
  logic [40:0] mu_sum;
  logic [N2_W-1:0] mu_num;
  always_comb begin
    mu_prod    = 41'(m_r.m) * 41'(e_r);
    mu_sum     = mu_prod + 41'd8192;
    mu_num     = {m_r.m, 14'd0} + N2_W'(e_r >> 1);
    mu_nxt.sb  = m_r.sb;
    mu_nxt.a   = m_r.a;
    mu_nxt.byp = m_r.byp;
    mu_nxt.qf  = mu_sum[14 +: Q_W];
    mu_nxt.rem = 16'(mu_num[N2_W-1:QDIV_W]);
    mu_nxt.low = mu_num[QDIV_W-1:0];
    mu_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (go[S_MU]) begin
      mu_r <= mu_nxt;
    end
  end

  // inverse scaling divider: (m * 2^14 + e/2) / e, one quotient bit per stage
  for (genvar i = 0; i < QDIV_W; i++) begin : g_dq
    dq_t         st_in;
    dq_t         st_nxt;
    logic [16:0] t;
    logic [16:0] tsub;
    logic        ge;
    if (i == 0) begin : g_first
      assign st_in = mu_r;
    end else begin : g_next
      assign st_in = dq_r[i-1];
    end
    always_comb begin
      t          = {st_in.rem, st_in.low[QDIV_W-1]};
      ge         = t >= {1'b0, e_r};
      tsub       = t - {1'b0, e_r};
      st_nxt     = st_in;
      st_nxt.rem = ge ? tsub[15:0] : t[15:0];
      st_nxt.low = st_in.low << 1;
      st_nxt.quo = {st_in.quo[QDIV_W-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (go[S_DQ+i]) begin
        dq_r[i] <= st_nxt;
      end
    end
  end

  // exp2 of the negated fraction: one root multiply per stage
  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_ex
    localparam logic [31:0] TK = root_const(k + 1);
    ex_t         st_in;
    ex_t         st_nxt;
    logic [63:0] prod;
    if (k == 0) begin : g_first
      always_comb begin
        st_in.sb   = dq_r[QDIV_W-1].sb;
        st_in.a    = dq_r[QDIV_W-1].a;
        st_in.byp  = dq_r[QDIV_W-1].byp;
        st_in.q    = dq_r[QDIV_W-1].sb.inv ? dq_r[QDIV_W-1].quo[Q_W-1:0]
                                            : dq_r[QDIV_W-1].qf;
        st_in.y    = '0;
        st_in.yone = 1'b1;
      end
    end else begin : g_next
      assign st_in = ex_r[k-1];
    end
    always_comb begin
      prod   = 64'(st_in.y) * 64'(TK);
      st_nxt = st_in;
      if (st_in.q[LOG_FRAC-1-k]) begin
        st_nxt.y    = st_in.yone ? TK : prod[63:32];
        st_nxt.yone = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      if (go[S_EX+k]) begin
        ex_r[k] <= st_nxt;
      end
    end
  end

  // integer shift, round to the output fraction, saturate at 1
  sh_t                 sh_nxt;
  logic [32:0]         sh_y;
  logic [33:0]         sh_sum;
  logic [FRAC_BITS+1:0] sh_b;
  always_comb begin
    sh_y   = {ex_r[LOG_FRAC-1].yone, ex_r[LOG_FRAC-1].y} >> ex_r[LOG_FRAC-1].q[Q_W-1:LOG_FRAC];
    sh_sum = 34'(sh_y) + (34'd1 << (31 - FRAC_BITS));
    sh_b   = sh_sum[33:32-FRAC_BITS];
    if (sh_b > (FRAC_BITS+2)'(ONE_A)) begin
      sh_b = (FRAC_BITS+2)'(ONE_A);
    end
    sh_nxt.sb = ex_r[LOG_FRAC-1].sb;
    sh_nxt.b  = ex_r[LOG_FRAC-1].byp ? ex_r[LOG_FRAC-1].a : sh_b[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (go[S_SH]) begin
      sh_r <= sh_nxt;
    end
  end

  // scale back into the half
  rr_t                  rr_nxt;
  logic [FRAC_BITS+16:0] rr_prod;
  always_comb begin
    rr_prod   = (FRAC_BITS+17)'(sh_r.b) * (FRAC_BITS+17)'(sh_r.sb.span)
                + ((FRAC_BITS+17)'(1) << (FRAC_BITS - 1));
    rr_nxt.sb = sh_r.sb;
    rr_nxt.r  = rr_prod[FRAC_BITS+16:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (go[S_R]) begin
      rr_r <= rr_nxt;
    end
  end

  // offset from the center, saturate to 16 bits
  logic signed [18:0] o_res;
  logic signed [15:0] out_nxt;
  always_comb begin
    if (rr_r.sb.upper) begin
      o_res = 19'(ctr_r) + signed'({2'b00, rr_r.r});
    end else begin
      o_res = 19'(ctr_r) - signed'({2'b00, rr_r.r});
    end
    if (rr_r.sb.empty) begin
      out_nxt = ctr_r;
    end else if (o_res > 19'sd32767) begin
      out_nxt = 16'sh7FFF;
    end else if (o_res < -19'sd32768) begin
      out_nxt = 16'sh8000;
    end else begin
      out_nxt = o_res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[S_O]) begin
      out_r <= out_nxt;
    end
  end

endmodule

[src/bpcm_checker.sv]
// bpcm_checker: port-level assertions for the power curve mapper
// depends on the top level's ports only; bound to bipolar_power_curve_mapper below

module bpcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_value_out
);

  // items taken in and not yet handed out
  logic [7:0] cnt_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 8'(in_xfer) - 8'(out_xfer);
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value_out))
    else $error("result changed while stalled");

  // no result without an item in flight
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 8'd0)
    else $error("result with no item in flight");

  // an empty pipeline always takes input
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 8'd0 |-> in_ready)
    else $error("empty pipeline refuses input");

  // reset clears the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bipolar_power_curve_mapper bpcm_checker u_bpcm_checker (.*);
